@@ rtl/cft_pkg.sv @@
// Shared types and constants for the CSV field tokenizer.
// No dependencies; imported by the channel interfaces and the tokenizer.
`default_nettype none

package cft_pkg;

  localparam logic [7:0] CharLf       = 8'd10;
  localparam logic [7:0] CharCr       = 8'd13;
  localparam logic [7:0] SepReset     = 8'd44;
  localparam logic [7:0] QuoteReset   = 8'd34;

  localparam logic       CfgSeparator = 1'b0;
  localparam logic       CfgQuote     = 1'b1;

  localparam logic [1:0] ModeStart    = 2'd0;
  localparam logic [1:0] ModePlain    = 2'd1;
  localparam logic [1:0] ModeQuoted   = 2'd2;
  localparam logic [1:0] ModeError    = 2'd3;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_out;
    logic       field_end;
    logic       record_end;
    logic       parse_error;
    logic       unclosed_quote;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       quote_pending;
    logic       cr_pending;
    logic       at_line_start;
  } pstate_t;

  typedef struct packed {
    pstate_t st;
    logic    em;
    res_t    r;
  } step_t;

endpackage

`default_nettype wire

@@ rtl/cft_in_if.sv @@
// Input channel of the CSV field tokenizer: one text byte or end mark per item.
// Depends on cft_pkg.
`default_nettype none

interface cft_in_if import cft_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

@@ rtl/cft_out_if.sv @@
// Result channel of the CSV field tokenizer: one token item per handshake.
// Depends on cft_pkg.
`default_nettype none

interface cft_out_if import cft_pkg::*;;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [7:0] char_out;
  logic       field_end;
  logic       record_end;
  logic       parse_error;
  logic       unclosed_quote;
  logic       last;

  modport source (output valid, output char_valid, output char_out, output field_end,
                  output record_end, output parse_error, output unclosed_quote,
                  output last, input ready);
  modport sink (input valid, input char_valid, input char_out, input field_end,
                input record_end, input parse_error, input unclosed_quote,
                input last, output ready);
endinterface

`default_nettype wire

@@ rtl/csv_field_tokenizer.sv @@
// CSV field tokenizer top level: parse state, config registers, result queue.
// Depends on cft_pkg, cft_in_if and cft_out_if.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    data_byte, end_of_input
//   out_ch   out  valid/ready    char_valid, char_out, field_end, record_end,
//                                parse_error, unclosed_quote, last
//   cfg_*    in   cfg_we         cfg_index (0 separator, 1 quote), cfg_data
//
// An item is parsed in the cycle it is accepted; its 0..2 results enter a
// 4-entry result queue and leave one per cycle unless out_ch stalls.
// in_ch.ready is high while the queue holds at most two entries, so items
// with zero or one result flow at one per cycle unless stalled; two-result
// items are bound by the single queue read port. Reset (rst_n low, synchronous)
// restores the parse state and config registers and empties the queue.
`default_nettype none

module csv_field_tokenizer import cft_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  cft_in_if.sink          in_ch,
  cft_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  function automatic res_t mk_res(logic cv, logic [7:0] ch, logic fe, logic re,
                                  logic err, logic unc);
    res_t r;
    r.char_valid     = cv;
    r.char_out       = cv ? ch : 8'd0;
    r.field_end      = fe;
    r.record_end     = re;
    r.parse_error    = err;
    r.unclosed_quote = unc;
    r.last           = 1'b0;
    return r;
  endfunction

  function automatic step_t line_end(pstate_t st, logic [7:0] q);
    step_t o;
    o.st = st;
    o.em = 1'b1;
    o.r  = '0;
    if (st.quote_pending) begin
      o.st.quote_pending = 1'b0;
      if (st.mode == ModeQuoted) begin
        o.r = mk_res(1'b0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b0);
      end else begin
        o.r = mk_res(1'b1, q, 1'b1, 1'b1, 1'b0, 1'b0);
      end
      o.st.mode = ModeStart;
    end else if (st.mode == ModeStart) begin
      o.r = mk_res(1'b0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
    end else if (st.mode == ModePlain) begin
      o.r       = mk_res(1'b0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b0);
      o.st.mode = ModeStart;
    end else begin
      o.r = mk_res(1'b1, CharLf, 1'b0, 1'b0, 1'b0, 1'b0);
    end
    o.st.at_line_start = 1'b1;
    return o;
  endfunction

  function automatic step_t take_byte(pstate_t st, logic [7:0] b, logic [7:0] sep,
                                      logic [7:0] q);
    step_t o;
    o.st = st;
    o.em = 1'b0;
    o.r  = '0;
    if (st.mode == ModeError) begin
      o.em = 1'b0;
    end else if (b == CharLf) begin
      o = line_end(st, q);
    end else begin
      o.st.at_line_start = 1'b0;
      if (st.quote_pending) begin
        o.st.quote_pending = 1'b0;
        o.em = 1'b1;
        if (b == q) begin
          o.r = mk_res(1'b1, q, 1'b0, 1'b0, 1'b0, 1'b0);
        end else if (b == sep && st.mode == ModeQuoted) begin
          o.r       = mk_res(1'b0, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0);
          o.st.mode = ModeStart;
        end else begin
          o.r       = mk_res(1'b0, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0);
          o.st.mode = ModeError;
        end
      end else if (st.mode == ModeStart) begin
        if (b == q) begin
          o.st.mode = ModeQuoted;
        end else if (b == sep) begin
          o.em = 1'b1;
          o.r  = mk_res(1'b0, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0);
        end else begin
          o.em      = 1'b1;
          o.r       = mk_res(1'b1, b, 1'b0, 1'b0, 1'b0, 1'b0);
          o.st.mode = ModePlain;
        end
      end else if (st.mode == ModePlain) begin
        if (b == q) begin
          o.st.quote_pending = 1'b1;
        end else if (b == sep) begin
          o.em      = 1'b1;
          o.r       = mk_res(1'b0, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0);
          o.st.mode = ModeStart;
        end else begin
          o.em = 1'b1;
          o.r  = mk_res(1'b1, b, 1'b0, 1'b0, 1'b0, 1'b0);
        end
      end else begin
        if (b == q) begin
          o.st.quote_pending = 1'b1;
        end else begin
          o.em = 1'b1;
          o.r  = mk_res(1'b1, b, 1'b0, 1'b0, 1'b0, 1'b0);
        end
      end
    end
    return o;
  endfunction

  function automatic step_t finish_input(pstate_t st, logic [7:0] q);
    step_t o;
    o.st = st;
    o.st.cr_pending = 1'b0;
    o.em = 1'b0;
    o.r  = '0;
    if (st.mode == ModeQuoted && !st.quote_pending) begin
      o.em = 1'b1;
      if (st.at_line_start) begin
        o.r = mk_res(1'b0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1);
      end else begin
        o.r = mk_res(1'b1, CharLf, 1'b1, 1'b1, 1'b0, 1'b1);
      end
    end else if (!(st.mode == ModeStart && st.at_line_start)) begin
      o = line_end(o.st, q);
    end
    o.st.mode          = ModeStart;
    o.st.quote_pending = 1'b0;
    o.st.at_line_start = 1'b1;
    return o;
  endfunction

  logic [7:0]       sep_r;
  logic [7:0]       quote_r;
  pstate_t          st_r;
  pstate_t          st_nxt;
  res_t             q_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r;
  logic [QPtrW-1:0] rd_ptr_r;
  logic [QCntW-1:0] cnt_r;

  step_t            s_a;
  step_t            s_b;
  res_t             res0;
  res_t             res1;
  logic [1:0]       n_res;
  logic             push;
  logic             pop;
  logic [1:0]       n_push;

  always_comb begin
    pstate_t s0;
    s0   = st_r;
    s_a  = '0;
    s_b  = '0;
    s_a.st = st_r;
    s_b.st = st_r;
    if (st_r.mode == ModeError) begin
      s_a.em = 1'b1;
      s_a.r  = mk_res(1'b0, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0);
      s_b.st = st_r;
    end else if (in_ch.end_of_input) begin
      s_a    = finish_input(st_r, quote_r);
      s_b.st = s_a.st;
    end else begin
      s0.cr_pending = 1'b0;
      if (st_r.cr_pending && in_ch.data_byte != CharLf) begin
        s_a = take_byte(s0, CharCr, sep_r, quote_r);
      end else begin
        s_a.st = s0;
      end
      s_b.st = s_a.st;
      if (s_a.st.mode != ModeError) begin
        if (in_ch.data_byte == CharCr) begin
          s_b.st.cr_pending    = 1'b1;
          s_b.st.at_line_start = 1'b0;
        end else begin
          s_b = take_byte(s_a.st, in_ch.data_byte, sep_r, quote_r);
        end
      end
    end
    st_nxt = s_b.st;
  end

  always_comb begin
    res0  = s_a.em ? s_a.r : s_b.r;
    res1  = s_b.r;
    n_res = {1'b0, s_a.em} + {1'b0, s_b.em};
    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

  assign in_ch.ready = (cnt_r <= QCntW'(QDepth - 2));
  assign push        = in_ch.valid & in_ch.ready;
  assign n_push      = push ? n_res : 2'd0;
  assign pop         = out_ch.valid & out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r   <= SepReset;
      quote_r <= QuoteReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgSeparator: sep_r   <= cfg_data;
        CfgQuote:     quote_r <= cfg_data;
        default:      sep_r   <= sep_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode          <= ModeStart;
      st_r.quote_pending <= 1'b0;
      st_r.cr_pending    <= 1'b0;
      st_r.at_line_start <= 1'b1;
      wr_ptr_r           <= '0;
      rd_ptr_r           <= '0;
      cnt_r              <= '0;
    end else begin
      if (push) begin
        st_r <= st_nxt;
      end
      wr_ptr_r <= wr_ptr_r + QPtrW'(n_push);
      rd_ptr_r <= rd_ptr_r + QPtrW'(pop);
      cnt_r    <= cnt_r + QCntW'(n_push) - QCntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      q_r[wr_ptr_r + QPtrW'(1)] <= res1;
    end
  end

  assign out_ch.valid          = (cnt_r != '0);
  assign out_ch.char_valid     = q_r[rd_ptr_r].char_valid;
  assign out_ch.char_out       = q_r[rd_ptr_r].char_out;
  assign out_ch.field_end      = q_r[rd_ptr_r].field_end;
  assign out_ch.record_end     = q_r[rd_ptr_r].record_end;
  assign out_ch.parse_error    = q_r[rd_ptr_r].parse_error;
  assign out_ch.unclosed_quote = q_r[rd_ptr_r].unclosed_quote;
  assign out_ch.last           = q_r[rd_ptr_r].last;

endmodule

`default_nettype wire

@@ sim/tb_csv_field_tokenizer.sv @@
// Self-checking testbench for csv_field_tokenizer: random-burst driver, stalling monitor,
// and a cycle-free token predictor checked against every result item.
// Depends on cft_pkg, cft_in_if, cft_out_if and the csv_field_tokenizer RTL.
`timescale 1ns / 1ps

module tb_csv_field_tokenizer;
  import cft_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       eoi;
  } text_item_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  cft_in_if  in_ch();
  cft_out_if out_ch();

  csv_field_tokenizer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predictor state and delimiter copy
  logic [1:0] pm;
  bit         qp;
  bit         crp;
  bit         als;
  logic [7:0] sep_r;
  logic [7:0] quo_r;
  res_t       step_res[$];
  res_t       token_q[$];

  text_item_t text_q[$];
  text_item_t nxt;
  int         burst_left = 8;
  int         gap_left = 0;
  int         n_pushed = 0;
  int         n_accepted = 0;
  int         n_checked = 0;
  int         n_errors = 0;
  int         n_settings = 0;
  logic [15:0] rdy_cnt = '0;
  int         stall_mode = 0;
  res_t       got;
  res_t       want;
  logic [7:0] rnd_sep;
  logic [7:0] rnd_quo;

  initial begin
    pm    = ModeStart;
    qp    = 1'b0;
    crp   = 1'b0;
    als   = 1'b1;
    sep_r = SepReset;
    quo_r = QuoteReset;
  end

  function automatic void emit_token(bit cv, logic [7:0] ch, bit fe, bit re, bit err, bit unc);
    res_t r;
    if (step_res.size() < 2) begin
      r.char_valid     = cv;
      r.char_out       = cv ? ch : 8'h00;
      r.field_end      = fe;
      r.record_end     = re;
      r.parse_error    = err;
      r.unclosed_quote = unc;
      r.last           = 1'b0;
      step_res.insert(step_res.size(), r);
    end
  endfunction

  function automatic void close_line();
    if (qp) begin
      qp = 1'b0;
      if (pm == ModeQuoted) emit_token(0, 8'h00, 1, 1, 0, 0);
      else emit_token(1, quo_r, 1, 1, 0, 0);
    end else if (pm == ModeStart) begin
      emit_token(0, 8'h00, 0, 1, 0, 0);
    end else if (pm == ModePlain) begin
      emit_token(0, 8'h00, 1, 1, 0, 0);
    end else begin
      emit_token(1, CharLf, 0, 0, 0, 0);
      als = 1'b1;
      return;
    end
    pm  = ModeStart;
    als = 1'b1;
  endfunction

  function automatic void feed_byte(logic [7:0] b);
    if (pm == ModeError) return;
    if (b == CharLf) begin
      close_line();
      return;
    end
    als = 1'b0;
    if (qp) begin
      qp = 1'b0;
      if (b == quo_r) begin
        emit_token(1, quo_r, 0, 0, 0, 0);
      end else if (b == sep_r && pm == ModeQuoted) begin
        emit_token(0, 8'h00, 1, 0, 0, 0);
        pm = ModeStart;
      end else begin
        pm = ModeError;
        emit_token(0, 8'h00, 0, 0, 1, 0);
      end
      return;
    end
    case (pm)
      ModeStart: begin
        if (b == quo_r) begin
          pm = ModeQuoted;
        end else if (b == sep_r) begin
          emit_token(0, 8'h00, 1, 0, 0, 0);
        end else begin
          emit_token(1, b, 0, 0, 0, 0);
          pm = ModePlain;
        end
      end
      ModePlain: begin
        if (b == quo_r) begin
          qp = 1'b1;
        end else if (b == sep_r) begin
          emit_token(0, 8'h00, 1, 0, 0, 0);
          pm = ModeStart;
        end else begin
          emit_token(1, b, 0, 0, 0, 0);
        end
      end
      default: begin
        if (b == quo_r) qp = 1'b1;
        else emit_token(1, b, 0, 0, 0, 0);
      end
    endcase
  endfunction

  function automatic void tokenize_item(logic [7:0] b, bit eoi);
    step_res.delete();
    if (pm == ModeError) begin
      emit_token(0, 8'h00, 0, 0, 1, 0);
    end else if (eoi) begin
      crp = 1'b0;
      if (pm == ModeQuoted && !qp) begin
        if (als) emit_token(0, 8'h00, 1, 1, 0, 1);
        else emit_token(1, CharLf, 1, 1, 0, 1);
      end else if (!(pm == ModeStart && als)) begin
        close_line();
      end
      pm  = ModeStart;
      qp  = 1'b0;
      als = 1'b1;
    end else begin
      if (crp) begin
        crp = 1'b0;
        if (b != CharLf) feed_byte(CharCr);
      end
      if (pm != ModeError) begin
        if (b == CharCr) begin
          crp = 1'b1;
          als = 1'b0;
        end else begin
          feed_byte(b);
        end
      end
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) token_q.insert(token_q.size(), step_res[i]);
  endfunction

  function automatic void push_byte(logic [7:0] b);
    text_item_t t;
    t.data_byte = b;
    t.eoi       = 1'b0;
    text_q.insert(text_q.size(), t);
    n_pushed++;
  endfunction

  function automatic void push_eoi();
    text_item_t t;
    t.data_byte = 8'($urandom);
    t.eoi       = 1'b1;
    text_q.insert(text_q.size(), t);
    n_pushed++;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 4) < 3) c = 8'($urandom_range(8'h20, 8'h7E));
      else c = 8'($urandom);
    end while (c == quo_r || c == sep_r || c == CharLf);
    return c;
  endfunction

  function automatic logic [7:0] quoted_char();
    logic [7:0] c;
    do begin
      case ($urandom_range(0, 15))
        0: c = sep_r;
        1: c = CharLf;
        2: c = CharCr;
        3, 4, 5: c = 8'($urandom);
        default: c = 8'($urandom_range(8'h20, 8'h7E));
      endcase
    end while (c == quo_r);
    return c;
  endfunction

  // well-formed record with random content; noise and cut-off endings mixed in
  function automatic void gen_record();
    int  nf;
    int  len;
    bit  quoted;
    bit  tail_quote;
    logic [7:0] c;
    tail_quote = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 5);
      for (int k = 0; k < len; k++) begin
        do c = 8'($urandom); while (c == quo_r);
        push_byte(c);
      end
      push_byte(CharLf);
    end
    if ($urandom_range(0, 11) == 0) push_byte(CharLf);
    nf = (sep_r == quo_r) ? 1 : $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) push_byte(sep_r);
      quoted = 1'($urandom_range(0, 1));
      len = $urandom_range(0, 6);
      if (quoted) begin
        push_byte(quo_r);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 7) == 0) begin
            push_byte(quo_r);
            push_byte(quo_r);
          end else begin
            push_byte(quoted_char());
          end
        end
        if ($urandom_range(0, 15) == 0) begin
          push_eoi();
          return;
        end
        push_byte(quo_r);
      end else begin
        for (int k = 0; k < len; k++) begin
          if (k > 0 && $urandom_range(0, 9) == 0) begin
            push_byte(quo_r);
            push_byte(quo_r);
          end else begin
            push_byte(plain_char());
          end
          if ($urandom_range(0, 40) == 0) begin
            push_eoi();
            return;
          end
        end
        if (f == nf - 1 && len > 0 && $urandom_range(0, 5) == 0) begin
          push_byte(quo_r);
          tail_quote = 1'b1;
        end
      end
    end
    if (nf > 1 && !tail_quote && $urandom_range(0, 9) == 0) push_byte(sep_r);
    case ($urandom_range(0, 9))
      6, 7: begin
        push_byte(CharCr);
        push_byte(CharLf);
      end
      8: push_eoi();
      9: begin
        push_byte(CharLf);
        push_eoi();
      end
      default: push_byte(CharLf);
    endcase
  endfunction

  task automatic wait_drained();
    do @(negedge clk); while (text_q.size() != 0 || in_ch.valid || token_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_delimiters(logic [7:0] sep, logic [7:0] quo);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CfgSeparator;
    cfg_data  <= sep;
    @(posedge clk);
    cfg_index <= CfgQuote;
    cfg_data  <= quo;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sep_r = sep;
    quo_r = quo;
    n_settings++;
  endtask

  task automatic run_phase(logic [7:0] sep, logic [7:0] quo, int n_items);
    int start;
    set_delimiters(sep, quo);
    start = n_pushed;
    while (n_pushed - start < n_items) gen_record();
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        tokenize_item(in_ch.data_byte, in_ch.end_of_input);
        n_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (text_q.size() > 0) begin
          nxt = text_q.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.data_byte    <= nxt.data_byte;
          in_ch.end_of_input <= nxt.eoi;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
            gap_left   = $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result item, stall on a changing pattern
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.char_valid     = out_ch.char_valid;
      got.char_out       = out_ch.char_out;
      got.field_end      = out_ch.field_end;
      got.record_end     = out_ch.record_end;
      got.parse_error    = out_ch.parse_error;
      got.unclosed_quote = out_ch.unclosed_quote;
      got.last           = out_ch.last;
      if (token_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 20)
          $display({"%0t: unexpected result item, expected none, ",
                    "actual cv=%b ch=%02h fe=%b re=%b pe=%b uq=%b last=%b"},
                   $time, got.char_valid, got.char_out, got.field_end, got.record_end,
                   got.parse_error, got.unclosed_quote, got.last);
      end else begin
        want = token_q.pop_front();
        n_checked++;
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 20)
            $display({"%0t: mismatch, ",
                      "expected cv=%b ch=%02h fe=%b re=%b pe=%b uq=%b last=%b, ",
                      "actual cv=%b ch=%02h fe=%b re=%b pe=%b uq=%b last=%b"},
                     $time, want.char_valid, want.char_out, want.field_end, want.record_end,
                     want.parse_error, want.unclosed_quote, want.last,
                     got.char_valid, got.char_out, got.field_end, got.record_end,
                     got.parse_error, got.unclosed_quote, got.last);
        end
      end
    end
    rdy_cnt <= rdy_cnt + 16'd1;
    if (rdy_cnt[5:0] == 6'd0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= rdy_cnt[2];
    endcase
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CfgSeparator;
    cfg_data           = 8'h00;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = 8'h00;
    in_ch.end_of_input = 1'b0;
    out_ch.ready       = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    push_text("\"a\"\"b\",");
    push_byte(8'hFF);
    push_byte(CharCr);
    push_byte(8'h00);
    push_byte(CharCr);
    push_byte(CharLf);
    push_byte(CharLf);
    push_text("x,\n");
    push_text("\"\n");
    push_text("a\"");
    push_byte(CharCr);
    push_byte(CharLf);
    push_text("b\"\n");
    push_text("\"q");
    push_eoi();
    push_eoi();
    wait_drained();

    run_phase(SepReset, QuoteReset, 150);
    run_phase(SepReset, QuoteReset, 150);
    run_phase(8'h00, 8'hFF, 120);
    run_phase(8'hFF, 8'h00, 120);
    run_phase(8'h3B, 8'h3B, 100);
    repeat (3) begin
      rnd_sep = 8'($urandom);
      do rnd_quo = 8'($urandom); while (rnd_quo == CharCr || rnd_quo == CharLf ||
                                         rnd_quo == rnd_sep);
      run_phase(rnd_sep, rnd_quo, 100);
    end
    run_phase(SepReset, QuoteReset, 100);

    // quote misuse last: the error holds until reset
    push_text("a\"b");
    push_text("c,\n");
    push_eoi();
    push_byte(8'($urandom));
    push_byte(quo_r);
    wait_drained();

    $display("Checked %0d result items from %0d text items over %0d delimiter settings,",
             n_checked, n_accepted, n_settings);
    $display("ending with quote misuse and its sticky error; %0d mismatches", n_errors);
    if (n_errors == 0 && token_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/cft_pkg.sv
rtl/cft_in_if.sv
rtl/cft_out_if.sv
rtl/csv_field_tokenizer.sv
sim/tb_csv_field_tokenizer.sv
